[hdl/hc2b_pkg.sv]
// ----------------------------------------------------------------------------
// hc2b_pkg
// Shared types, register indexes and mod-26 helpers for the 2x2 Hill block.
// ----------------------------------------------------------------------------
package hc2b_pkg;

    localparam int unsigned MODULUS     = 26;
    localparam int unsigned LETTER_BASE = 65;
    // floor(2^16 / 26): quotient estimate is exact or one short
    localparam int unsigned RECIP       = 2520;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_R0C0  = 3'd0;
    localparam logic [2:0] REG_KEY_R0C1  = 3'd1;
    localparam logic [2:0] REG_KEY_R1C0  = 3'd2;
    localparam logic [2:0] REG_KEY_R1C1  = 3'd3;
    localparam logic [2:0] REG_DECRYPT   = 3'd4;

    localparam logic [4:0] KEY_R0C0_RST = 5'd9;
    localparam logic [4:0] KEY_R0C1_RST = 5'd4;
    localparam logic [4:0] KEY_R1C0_RST = 5'd5;
    localparam logic [4:0] KEY_R1C1_RST = 5'd7;

    typedef logic [4:0] res_t;   // residue 0..25
    typedef logic [6:0] char_t;  // ASCII letter

    // 2x2 matrix, row-major: [0]=r0c0 [1]=r0c1 [2]=r1c0 [3]=r1c1
    typedef res_t [3:0] mat_t;

    typedef struct packed {
        mat_t m;    // working key (key or inverse key)
        logic err;  // decrypting with a singular key
    } key_mat_t;

    typedef struct packed {
        logic ld_sum;     // load lane product stage
        logic ld_letter;  // load lane letter stage
    } lane_ctl_t;

    // v mod 26 by reciprocal multiply and one correction
    function automatic res_t mod26(input logic [10:0] v);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [10:0] r;
        prod = 23'(v) * 23'(RECIP);
        q    = prod[22:16];
        r    = v - 11'(11'(q) * 11'(MODULUS));
        if (r >= 11'(MODULUS))
        begin
            r = r - 11'(MODULUS);
        end
        return res_t'(r[4:0]);
    endfunction

    // multiplicative inverse mod 26, 0 where none exists
    function automatic res_t inv_lookup(input res_t d);
        res_t inv;
        case (d)
            5'd1:    inv = 5'd1;
            5'd3:    inv = 5'd9;
            5'd5:    inv = 5'd21;
            5'd7:    inv = 5'd15;
            5'd9:    inv = 5'd3;
            5'd11:   inv = 5'd19;
            5'd15:   inv = 5'd7;
            5'd17:   inv = 5'd23;
            5'd19:   inv = 5'd11;
            5'd21:   inv = 5'd5;
            5'd23:   inv = 5'd17;
            5'd25:   inv = 5'd25;
            default: inv = 5'd0;
        endcase
        return inv;
    endfunction

endpackage

[hdl/hc2b_key_prep.sv]
// ----------------------------------------------------------------------------
// hc2b_key_prep
// Key registers and two-stage derivation of the working key matrix.
// ----------------------------------------------------------------------------
module hc2b_key_prep
    import hc2b_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_wdata,
    output key_mat_t   key_mat
);

    logic [4:0] key00_reg;
    logic [4:0] key01_reg;
    logic [4:0] key10_reg;
    logic [4:0] key11_reg;
    logic       decrypt_reg;

    mat_t kr;
    res_t det;
    res_t inv;
    mat_t base_next;
    mat_t base_reg;
    res_t mult_next;
    res_t mult_reg;
    logic err_next;
    logic err1_reg;
    mat_t m_next;
    mat_t m_reg;
    logic err2_reg;

    function automatic res_t reduce(input logic [4:0] k);
        return (k >= 5'(MODULUS)) ? res_t'(k - 5'(MODULUS)) : k;
    endfunction

    function automatic res_t negate(input res_t k);
        return (k == 5'd0) ? 5'd0 : res_t'(5'(MODULUS) - k);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key00_reg   <= KEY_R0C0_RST;
            key01_reg   <= KEY_R0C1_RST;
            key10_reg   <= KEY_R1C0_RST;
            key11_reg   <= KEY_R1C1_RST;
            decrypt_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KEY_R0C0: key00_reg   <= cfg_wdata;
                REG_KEY_R0C1: key01_reg   <= cfg_wdata;
                REG_KEY_R1C0: key10_reg   <= cfg_wdata;
                REG_KEY_R1C1: key11_reg   <= cfg_wdata;
                REG_DECRYPT:  decrypt_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // stage 1: determinant, its inverse, adjugate (the key as is when encrypting)
    always_comb
    begin
        kr[0] = reduce(key00_reg);
        kr[1] = reduce(key01_reg);
        kr[2] = reduce(key10_reg);
        kr[3] = reduce(key11_reg);
        det   = mod26(11'(kr[0] * kr[3]) + 11'(MODULUS * MODULUS)
                      - 11'(kr[1] * kr[2]));
        inv   = inv_lookup(det);
        if (decrypt_reg)
        begin
            base_next[0] = kr[3];
            base_next[1] = negate(kr[1]);
            base_next[2] = negate(kr[2]);
            base_next[3] = kr[0];
            mult_next    = inv;
            err_next     = (inv == 5'd0);
        end
        else
        begin
            base_next = kr;
            mult_next = 5'd1;
            err_next  = 1'b0;
        end
    end

    // stage 2: scale adjugate by inverse determinant (singular key gives zeros; scale 1 when encrypting)
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            m_next[i] = mod26(11'(base_reg[i] * mult_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= {KEY_R1C1_RST, KEY_R1C0_RST, KEY_R0C1_RST, KEY_R0C0_RST};
            mult_reg <= 5'd1;
            err1_reg <= 1'b0;
            m_reg    <= {KEY_R1C1_RST, KEY_R1C0_RST, KEY_R0C1_RST, KEY_R0C0_RST};
            err2_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            mult_reg <= mult_next;
            err1_reg <= err_next;
            m_reg    <= m_next;
            err2_reg <= err1_reg;
        end
    end

    assign key_mat.m   = m_reg;
    assign key_mat.err = err2_reg;

endmodule

[hdl/hc2b_lane.sv]
// ----------------------------------------------------------------------------
// hc2b_lane
// One result element: dot product of a key row and a text column, mod 26.
// ----------------------------------------------------------------------------
module hc2b_lane
    import hc2b_pkg::*;
(
    input  logic      clk,
    input  lane_ctl_t ctl,
    input  res_t      key_0,
    input  res_t      key_1,
    input  res_t      txt_0,
    input  res_t      txt_1,
    output char_t     letter
);

    logic [10:0] sum_reg;
    logic [10:0] sum_next;
    char_t       letter_reg;
    char_t       letter_next;

    assign sum_next    = 11'(key_0 * txt_0) + 11'(key_1 * txt_1);
    assign letter_next = 7'(LETTER_BASE) + 7'(mod26(sum_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.ld_letter)
        begin
            letter_reg <= letter_next;
        end
    end

    assign letter = letter_reg;

endmodule

[hdl/hc2b_merge.sv]
// ----------------------------------------------------------------------------
// hc2b_merge
// Gathers the four lane letters and the key flag into the output register.
// ----------------------------------------------------------------------------
module hc2b_merge
    import hc2b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  char_t [3:0] letters,
    input  logic        key_err,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser
);

    logic        valid_reg;
    logic [27:0] data_reg;
    logic        err_reg;

    assign in_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= {letters[3], letters[2], letters[1], letters[0]};
            err_reg  <= key_err;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, data_reg};
    assign m_axis_tuser  = err_reg;

endmodule

[hdl/hill_cipher_2x2_block_unit.sv]
// ----------------------------------------------------------------------------
// hill_cipher_2x2_block_unit
// 2x2 Hill cipher mod 26, one four-letter block per request.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: one request carries a 2x2 block of ASCII letters.
//  - Output stream: the enciphered (or deciphered) block plus a key error
//    flag, set when decrypting with a key whose determinant has no inverse
//    mod 26; the letters are then all 'A'.
//  - Config port: write enable, index and data. Write the key and the mode
//    only while no request is in flight; the derived key is registered
//    in key preparation and is in place when a following request reaches
//    the lanes. Stages: raw letters, letter indices, lane sums, lane
//    letters, output. One request per cycle, receiver permitting, set by
//    four parallel lanes (one per result element) fed by a fixed working key.
//  - Stall: each stage loads whenever it is empty or its successor moves,
//    so bubbles are squeezed out and new requests are taken while a result
//    waits; with the pipe full and the receiver stalled, tready drops.
//  - Reset: pipe emptied, key back to its reset values, encrypt mode.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_block_unit
    import hc2b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // letter_a, letter_b, letter_c, letter_d, pad
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_letter_a .. out_letter_d, pad
    output logic [0:0]  m_axis_tuser    // key_error
);

    key_mat_t    key_mat;

    // stage 1: raw letters
    logic        v1_reg;
    char_t [3:0] raw_reg;
    // stage 2: letter indices
    logic        v2_reg;
    mat_t        txt_reg;
    mat_t        txt_next;
    // stages 3 and 4 live in the lanes
    logic        v3_reg;
    logic        v4_reg;

    logic        rdy1;
    logic        rdy2;
    logic        rdy3;
    logic        rdy4;
    logic        rdy5;
    lane_ctl_t   lane_ctl;
    char_t [3:0] lane_letter;

    hc2b_key_prep u_key_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key_mat   (key_mat)
    );

    // ready chain: a stage moves when it is empty or the next one moves
    assign rdy4          = !v4_reg || rdy5;
    assign rdy3          = !v3_reg || rdy4;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign lane_ctl.ld_sum    = rdy3 && v2_reg;
    assign lane_ctl.ld_letter = rdy4 && v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // letter index: (code - 'A') mod 26, offset by 3*26 to stay positive
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            txt_next[i] = mod26(11'(raw_reg[i]) + 11'(3 * MODULUS - LETTER_BASE));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            raw_reg[0] <= s_axis_tdata[6:0];
            raw_reg[1] <= s_axis_tdata[13:7];
            raw_reg[2] <= s_axis_tdata[20:14];
            raw_reg[3] <= s_axis_tdata[27:21];
        end
        if (rdy2 && v1_reg)
        begin
            txt_reg <= txt_next;
        end
    end

    // one lane per result element: row i of the key times column j of text
    for (genvar e = 0; e < 4; e++)
    begin : g_lane
        localparam int Row = e / 2;
        localparam int Col = e % 2;
        hc2b_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .key_0  (key_mat.m[Row * 2]),
            .key_1  (key_mat.m[Row * 2 + 1]),
            .txt_0  (txt_reg[Col]),
            .txt_1  (txt_reg[2 + Col]),
            .letter (lane_letter[e])
        );
    end

    hc2b_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (v4_reg),
        .in_ready      (rdy5),
        .letters       (lane_letter),
        .key_err       (key_mat.err),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[tb/hill_block_checker.sv]
// ----------------------------------------------------------------------------
// hill_block_checker
// Watches the key port and both streams of the 2x2 Hill block, works out the
// enciphered or deciphered letters for every accepted request and compares
// each returned block, letter by letter and the key error flag, in order.
// ----------------------------------------------------------------------------
module hill_block_checker
    import hc2b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          mismatch_count,
    output int          blocks_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            key_err;
        char_t [3:0]     ltr;     // row-major, [0] = row 0 column 0
    } hill_result_t;

    hill_result_t pending_blocks [$];
    logic [4:0]   key_copy [4];
    logic         decrypt_copy;

    // letters of one request -> expected block under the current key
    function automatic hill_result_t cipher_block(input logic [27:0] letters);
        int unsigned  key [4];
        int unsigned  mat [4];
        int unsigned  txt [4];
        int unsigned  det;
        int unsigned  inv;
        int unsigned  v;
        logic         singular;
        hill_result_t res;
        for (int i = 0; i < 4; i++)
        begin
            key[i] = key_copy[i] % MODULUS;
            txt[i] = (int'(letters[7*i +: 7]) + 3 * MODULUS - LETTER_BASE) % MODULUS;
        end
        singular = 1'b0;
        if (decrypt_copy)
        begin
            det = (key[0] * key[3] + MODULUS * MODULUS - key[1] * key[2]) % MODULUS;
            inv = 0;
            for (int n = 1; n < 26; n++)
            begin
                if ((det * n) % MODULUS == 1)
                begin
                    inv = n;
                end
            end
            singular = (inv == 0);
            // adjugate scaled by the inverse determinant
            mat[0] = (key[3] * inv) % MODULUS;
            mat[3] = (key[0] * inv) % MODULUS;
            mat[1] = (((MODULUS - key[1]) % MODULUS) * inv) % MODULUS;
            mat[2] = (((MODULUS - key[2]) % MODULUS) * inv) % MODULUS;
        end
        else
        begin
            mat = key;
        end
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                v = (mat[2*r] * txt[c] + mat[2*r+1] * txt[2+c]) % MODULUS;
                if (singular)
                begin
                    v = 0;
                end
                res.ltr[2*r+c] = char_t'(v + LETTER_BASE);
            end
        end
        res.key_err = singular;
        return res;
    endfunction

    task automatic report_fault(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hill_result_t got;
        hill_result_t want;
        if (!rst_n)
        begin
            key_copy[0]  <= KEY_R0C0_RST;
            key_copy[1]  <= KEY_R0C1_RST;
            key_copy[2]  <= KEY_R1C0_RST;
            key_copy[3]  <= KEY_R1C1_RST;
            decrypt_copy <= 1'b0;
            pending_blocks.delete();
            blocks_in_flight <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_KEY_R0C0: key_copy[0]  <= cfg_wdata;
                    REG_KEY_R0C1: key_copy[1]  <= cfg_wdata;
                    REG_KEY_R1C0: key_copy[2]  <= cfg_wdata;
                    REG_KEY_R1C1: key_copy[3]  <= cfg_wdata;
                    REG_DECRYPT:  decrypt_copy <= cfg_wdata[0];
                    default:      ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_blocks.push_back(cipher_block(s_axis_tdata[27:0]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    got.ltr[i] = m_axis_tdata[7*i +: 7];
                end
                got.key_err = m_axis_tuser[0];
                if (pending_blocks.size() == 0)
                begin
                    report_fault($sformatf("result with no request pending: %h/%b",
                                           m_axis_tdata, m_axis_tuser));
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got.ltr[i] !== want.ltr[i])
                        begin
                            report_fault($sformatf("letter %0d: expected %0d, got %0d",
                                                   i, want.ltr[i], got.ltr[i]));
                        end
                    end
                    if (got.key_err !== want.key_err)
                    begin
                        report_fault($sformatf("key_error: expected %b, got %b",
                                               want.key_err, got.key_err));
                    end
                end
            end
            blocks_in_flight <= pending_blocks.size();
        end
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the 2x2 Hill block with directed and random letter blocks under a
// series of keys and modes; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module testbench
    import hc2b_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // no register lives here; writes to it must change nothing
    localparam logic [2:0] REG_UNUSED      = 3'd7;
    localparam int         PRESSURE_CYCLES = 60;
    localparam int         KEY_PHASES      = 11;
    localparam int         PHASE_BLOCKS    = 118;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // letter_a, letter_b, letter_c, letter_d, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // out_letter_a .. out_letter_d, pad
    logic [0:0]  m_axis_tuser;    // key_error

    int          mismatch_count;
    int          blocks_in_flight;

    // steady flow when set: neither side idles
    logic        calm;
    // asks the receiver for its one long hold-off
    logic        pressure_go;

    hill_cipher_2x2_block_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hill_block_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .mismatch_count   (mismatch_count),
        .blocks_in_flight (blocks_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // mostly A-Z, with a share of raw 7-bit codes and the two neighbours of
    // the alphabet, which wrap round to Z and A
    function automatic char_t rand_letter();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 88)
        begin
            return char_t'($urandom_range(65, 90));
        end
        else if (r < 94)
        begin
            return char_t'($urandom_range(0, 127));
        end
        else if (r < 97)
        begin
            return char_t'("@");
        end
        return char_t'("[");
    endfunction

    function automatic logic [31:0] rand_text();
        return {1'b0, rand_letter(), 1'b0, rand_letter(),
                1'b0, rand_letter(), 1'b0, rand_letter()};
    endfunction

    // key element: mostly in range, some needing the mod 26 fold, some extremes
    function automatic logic [4:0] rand_key_elem();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
        begin
            return 5'($urandom_range(0, 25));
        end
        else if (r < 90)
        begin
            return 5'($urandom_range(26, 31));
        end
        return (r < 95) ? 5'd0 : 5'd25;
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (blocks_in_flight != 0);
    endtask

    // one request; txt holds four 8-bit codes, the first letter in the top byte
    task automatic send_text(input logic [31:0] txt);
        while (!calm && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, txt[6:0], txt[14:8], txt[22:16], txt[30:24]};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // key and mode change only once every request has come back
    task automatic program_key(input logic [4:0] k00, input logic [4:0] k01,
                               input logic [4:0] k10, input logic [4:0] k11,
                               input logic mode);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_write(REG_KEY_R0C0, k00);
        cfg_write(REG_KEY_R0C1, k01);
        cfg_write(REG_KEY_R1C0, k10);
        cfg_write(REG_KEY_R1C1, k11);
        // upper data bits are don't-care for the mode register
        cfg_write(REG_DECRYPT, {4'($urandom_range(15)), mode});
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off so the pipe backs up
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_go && !held)
            begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial
    begin : stimulus
        logic [4:0] k [4];
        int unsigned pick;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        calm        = 1'b0;
        pressure_go = 1'b0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key, encrypt: letter extremes and codes outside A-Z
        send_text("AAAA");
        send_text("ZZZZ");
        send_text("HELP");
        send_text("@@@@");
        send_text("[[[[");
        send_text(32'h007F_007F);
        send_text(32'h7F00_7F00);

        // reset key is invertible: plain decrypt
        program_key(KEY_R0C0_RST, KEY_R0C1_RST, KEY_R1C0_RST, KEY_R1C1_RST, 1'b1);
        send_text("HELP");
        send_text("ZAZA");

        // singular keys while decrypting: determinant 0, then 13
        program_key(5'd2, 5'd4, 5'd1, 5'd2, 1'b1);
        send_text("ABCD");
        send_text("ZZZZ");
        program_key(5'd13, 5'd0, 5'd0, 5'd1, 1'b1);
        send_text("QRST");
        // same key in encrypt mode raises no error
        program_key(5'd13, 5'd0, 5'd0, 5'd1, 1'b0);
        send_text("QRST");

        // key elements above 25 fold back mod 26
        program_key(5'd31, 5'd30, 5'd27, 5'd26, 1'b0);
        send_text("MNOP");
        send_text("ZZZZ");
        program_key(5'd27, 5'd26, 5'd26, 5'd27, 1'b1);
        send_text("WXYZ");

        // a write to an unmapped index must leave the key alone
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_write(REG_UNUSED, 5'd31);
        cfg_wr_en <= 1'b0;
        send_text("WXYZ");

        // all-zero key, all-25 key, diagonal key of 25s
        program_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
        send_text("KEYS");
        program_key(5'd25, 5'd25, 5'd25, 5'd25, 1'b1);
        send_text("KEYS");
        program_key(5'd25, 5'd0, 5'd0, 5'd25, 1'b1);
        send_text("KEYS");

        // random phases: fresh key and mode each time
        for (int phase = 0; phase < KEY_PHASES; phase++)
        begin
            pick = $urandom_range(9);
            for (int i = 0; i < 4; i++)
            begin
                case (pick)
                    0:       k[i] = 5'd0;
                    1:       k[i] = 5'd25;
                    2:       k[i] = 5'd31;
                    default: k[i] = rand_key_elem();
                endcase
            end
            program_key(k[0], k[1], k[2], k[3], 1'($urandom_range(1)));
            calm = (phase == 2);
            if (phase == 5)
            begin
                pressure_go = 1'b1;
            end
            repeat (PHASE_BLOCKS) send_text(rand_text());
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        // catch any stray result after the last one
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && blocks_in_flight == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/hc2b_pkg.sv
hdl/hc2b_key_prep.sv
hdl/hc2b_lane.sv
hdl/hc2b_merge.sv
hdl/hill_cipher_2x2_block_unit.sv
tb/hill_block_checker.sv
tb/testbench.sv
